>>> rtl/core/lpfp_pkg.sv
// shared types and constants of the length-prefixed frame parser
// no dependencies; imported by lpfp_step, length_prefixed_frame_parser and lpfp_checker
`default_nettype none

package lpfp_pkg;

    localparam logic [7:0]  MAGIC_BYTE   = 8'h46;
    localparam logic [1:0]  LAST_HDR_IDX = 2'd3;  // four bytes per length field

    // section tags on the result
    localparam logic [2:0] SEC_MAGIC = 3'd0;
    localparam logic [2:0] SEC_MLEN  = 3'd1;
    localparam logic [2:0] SEC_VLEN  = 3'd2;
    localparam logic [2:0] SEC_MSG   = 3'd3;
    localparam logic [2:0] SEC_VAL   = 3'd4;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_MLEN  = 3'd1,
        PH_VLEN  = 3'd2,
        PH_MSG   = 3'd3,
        PH_VAL   = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  hdr_cnt;
        logic [31:0] msg_len;
        logic [31:0] val_len;
        logic [31:0] remaining;
    } t_state;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  section;
        logic        section_last;
        logic [31:0] length_word;
        logic        frame_done;
        logic        bad_magic;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/length_prefixed_frame_parser.sv
// top level of the length-prefixed frame parser: input register, parse step, result register
// depends on lpfp_pkg and lpfp_step
`default_nettype none

// Splits a byte stream into frames of the form: magic byte 0x46, 4-byte big-endian
// message length, 4-byte big-endian value length, message bytes, value bytes. Every
// accepted byte yields exactly one result request carrying the byte, its section
// (0 magic, 1 message length, 2 value length, 3 message, 4 value), an end-of-section
// flag, the decoded length on the last byte of a length field (zero otherwise), a
// frame-done flag on the final byte of a frame and a bad-magic flag when a byte in
// the magic position is not 0x46 (hunting then continues). Empty sections are skipped.
// One byte per clock is sustained while the downstream side does not stall: a request
// sits in the input register, where the parse step (a 32-bit decrement and zero
// compare) runs, and then lands in the result register. The result register holds
// while the downstream side stalls and the input register keeps taking a new request
// as long as the result register can move.

module length_prefixed_frame_parser
    import lpfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    // result request channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_section,
    output logic        o_section_last,
    output logic [31:0] o_length_word,
    output logic        o_frame_done,
    output logic        o_bad_magic
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // parser state and result register
    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;

    logic w_advance;   // input register moves into result register
    logic w_load;      // new request taken into input register

    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;
    assign w_load    = i_valid && !o_stall;

    lpfp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{phase: PH_MAGIC, hdr_cnt: 2'd0, msg_len: 32'd0,
                             val_len: 32'd0, remaining: 32'd0};
        end else begin
            if (w_load) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_byte <= i_stream_byte;
        end
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_result.out_byte;
    assign o_section      = r_result.section;
    assign o_section_last = r_result.section_last;
    assign o_length_word  = r_result.length_word;
    assign o_frame_done   = r_result.frame_done;
    assign o_bad_magic    = r_result.bad_magic;

endmodule

`default_nettype wire

>>> rtl/core/lpfp_step.sv
// per-byte parse step: next parser state and tagged result for one byte
// depends on lpfp_pkg
`default_nettype none

module lpfp_step
    import lpfp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_state,
    output t_result    o_result
);

    logic [31:0] w_mlen_sh;
    logic [31:0] w_vlen_sh;
    logic [31:0] w_dec;

    assign w_mlen_sh = {i_state.msg_len[23:0], i_byte};
    assign w_vlen_sh = {i_state.val_len[23:0], i_byte};
    assign w_dec     = i_state.remaining - 32'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.out_byte = i_byte;
        case (i_state.phase)
            PH_MLEN: begin
                o_result.section = SEC_MLEN;
                o_state.msg_len  = w_mlen_sh;
                if (i_state.hdr_cnt == LAST_HDR_IDX) begin
                    o_result.section_last = 1'b1;
                    o_result.length_word  = w_mlen_sh;
                    o_state.hdr_cnt       = 2'd0;
                    o_state.phase         = PH_VLEN;
                end else begin
                    o_state.hdr_cnt = i_state.hdr_cnt + 2'd1;
                end
            end
            PH_VLEN: begin
                o_result.section = SEC_VLEN;
                o_state.val_len  = w_vlen_sh;
                if (i_state.hdr_cnt == LAST_HDR_IDX) begin
                    o_result.section_last = 1'b1;
                    o_result.length_word  = w_vlen_sh;
                    o_state.hdr_cnt       = 2'd0;
                    if (i_state.msg_len != 32'd0) begin
                        o_state.phase     = PH_MSG;
                        o_state.remaining = i_state.msg_len;
                    end else if (w_vlen_sh != 32'd0) begin
                        o_state.phase     = PH_VAL;
                        o_state.remaining = w_vlen_sh;
                    end else begin
                        // empty message and empty value
                        o_state.phase       = PH_MAGIC;
                        o_state.remaining   = 32'd0;
                        o_result.frame_done = 1'b1;
                    end
                end else begin
                    o_state.hdr_cnt = i_state.hdr_cnt + 2'd1;
                end
            end
            PH_MSG: begin
                o_result.section  = SEC_MSG;
                o_state.remaining = w_dec;
                if (w_dec == 32'd0) begin
                    o_result.section_last = 1'b1;
                    if (i_state.val_len != 32'd0) begin
                        o_state.phase     = PH_VAL;
                        o_state.remaining = i_state.val_len;
                    end else begin
                        o_state.phase       = PH_MAGIC;
                        o_result.frame_done = 1'b1;
                    end
                end
            end
            PH_VAL: begin
                o_result.section  = SEC_VAL;
                o_state.remaining = w_dec;
                if (w_dec == 32'd0) begin
                    o_result.section_last = 1'b1;
                    o_result.frame_done   = 1'b1;
                    o_state.phase         = PH_MAGIC;
                end
            end
            default: begin
                // magic hunt, also taken for unused phase codes
                o_result.section = SEC_MAGIC;
                o_state.hdr_cnt  = 2'd0;
                if (i_byte == MAGIC_BYTE) begin
                    o_result.section_last = 1'b1;
                    o_state.msg_len       = 32'd0;
                    o_state.val_len       = 32'd0;
                    o_state.remaining     = 32'd0;
                    o_state.phase         = PH_MLEN;
                end else begin
                    o_result.bad_magic = 1'b1;
                    o_state.phase      = PH_MAGIC;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/lpfp_checker.sv
// port-level checks on the length-prefixed frame parser, bound to the top level
// depends on lpfp_pkg and length_prefixed_frame_parser
`default_nettype none

module lpfp_checker
    import lpfp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_out_byte,
    input wire logic [2:0]  o_section,
    input wire logic        o_section_last,
    input wire logic [31:0] o_length_word,
    input wire logic        o_frame_done,
    input wire logic        o_bad_magic
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // frame end always closes a body or length section
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_section_last && o_section != SEC_MAGIC)
        else $error("frame_done without section end");

    // a bad magic byte is tagged as magic and never ends a section
    a_bad_magic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_magic |->
            o_section == SEC_MAGIC && !o_section_last && !o_frame_done)
        else $error("bad_magic with wrong tags");

    // a length is only reported on the last byte of a length field
    a_length_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_length_word != 32'd0 |->
            o_section_last && (o_section == SEC_MLEN || o_section == SEC_VLEN))
        else $error("length_word outside a length field end");

    // stalled result holds its byte and section
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_section))
        else $error("stalled result changed");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);

`default_nettype wire
